[src/fse_pkg.sv]
// Shared constants, types and register codes for the focal-sum ellipsoid test.
package fse_pkg;

  // Largest vector length held in the focus stores (2 .. 64)
  localparam int DimMax  = 16;
  localparam int AddrW   = (DimMax > 1) ? $clog2(DimMax) : 1;
  // Wide enough for DimMax up to 64 and for the 5-bit dimension register
  localparam int CmpW    = 8;

  localparam int FuncW   = 1;
  localparam int IdxW    = 4;
  localparam int ValW    = 16;
  localparam int MagW    = 16;
  localparam int ProdW   = 2 * MagW;
  localparam int SumW    = 38;
  localparam int RootW   = SumW / 2;
  localparam int LenW    = 20;
  localparam int DimW    = 5;
  localparam int DiamW   = 20;
  localparam int RamW    = 2 * ValW;

  localparam int InDataW  = 40;
  localparam int OutDataW = 24;
  localparam int PaddrW   = 3;
  localparam int PdataW   = 32;

  localparam logic [DimW-1:0]  DimReset  = DimW'(2);
  localparam logic [DiamW-1:0] DiamReset = '0;

  // Word index of each configuration register (paddr bit 2)
  localparam logic RegDimension = 1'b0;
  localparam logic RegDiameter  = 1'b1;

  // Input item kinds
  localparam logic [FuncW-1:0] FuncLoad  = 1'b0;
  localparam logic [FuncW-1:0] FuncPoint = 1'b1;

  // Result status codes
  localparam logic StatusOk     = 1'b0;
  localparam logic StatusNotSet = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_ACC,
    ST_START,
    ST_ROOT,
    ST_DONE
  } fse_state_e;

  typedef struct packed {
    logic start;
    logic busy;
  } fse_root_ctl_t;

  function automatic logic [AddrW-1:0] to_addr(input logic [IdxW-1:0] idx);
    return AddrW'(idx);
  endfunction

endpackage

[src/fse_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fse_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                     wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/fse_isqrt.sv]
// Iterative floor square root, one root bit resolved per cycle.
module fse_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [fse_pkg::SumW-1:0]      op_i,
  output logic                          busy_o,
  output logic [fse_pkg::RootW-1:0]     root_o
);
  import fse_pkg::*;

  localparam logic [SumW-1:0] BitInit = SumW'(1) << (2 * (RootW - 1));

  logic            busy_q, busy_d;
  logic [SumW-1:0] rem_q, rem_d;
  logic [SumW-1:0] res_q, res_d;
  logic [SumW-1:0] bit_q, bit_d;
  logic [SumW-1:0] trial;

  assign trial = res_q + bit_q;

  always_comb begin
    busy_d = busy_q;
    rem_d  = rem_q;
    res_d  = res_q;
    bit_d  = bit_q;
    if (start_i) begin
      busy_d = 1'b1;
      rem_d  = op_i;
      res_d  = '0;
      bit_d  = BitInit;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_d = rem_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign busy_o = busy_q;
  assign root_o = res_q[RootW-1:0];

endmodule

[src/focal_sum_ellipsoid_test_top.sv]
// Top level of the focal-sum ellipsoid membership test.
//
// Channel  | Dir | Words                                        | Handshake
// ---------+-----+----------------------------------------------+----------------
// s_axis   | in  | load focus coords (tuser 0) or point coord   | tvalid/tready
// m_axis   | out | one result word per point (on tlast input)   | tvalid/tready
// apb      | in  | dimension @0x0, transverse_diameter @0x4     | pready tied high
//
// Sequence: a load word is taken in idle; a point coordinate passes MUL1 and
//   MUL2, as the single 16x16 squaring multiplier is used once per focus. The
//   word marked tlast then passes ACC to settle the second sum, START, 19 steps
//   of the two parallel iterative square-root units, ROOT to see them done, and
//   DONE to register the result once the output register is free.
// Reset: asynchronous, active low; sums and control clear, focus RAM is not
//   cleared (no clearing pass), registers return to dimension 2, diameter 0.
// Stalls: the output register frees the input side; a new point is taken while
//   a result waits, and only the next result waits for m_axis_tready.
module focal_sum_ellipsoid_test_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // s_axis
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [3:0] index, [19:4] value_a, [35:20] value_b, [39:36] zero
  input  logic [fse_pkg::InDataW-1:0]    s_axis_tdata_i,
  // [0] func
  input  logic                           s_axis_tuser_i,
  input  logic                           s_axis_tlast_i,
  // m_axis
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [0] inside_res, [1] on_surface, [21:2] path_length, [23:22] zero
  output logic [fse_pkg::OutDataW-1:0]   m_axis_tdata_o,
  // [0] status
  output logic                           m_axis_tuser_o,
  // apb
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fse_pkg::PaddrW-1:0]     paddr,
  input  logic [fse_pkg::PdataW-1:0]     pwdata,
  output logic [fse_pkg::PdataW-1:0]     prdata,
  output logic                           pready
);
  import fse_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DimW-1:0]  dim_q;
  logic [DiamW-1:0] diam_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q  <= DimReset;
      diam_q <= DiamReset;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegDimension: dim_q  <= pwdata[DimW-1:0];
        RegDiameter:  diam_q <= pwdata[DiamW-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegDimension: prdata = PdataW'(dim_q);
      RegDiameter:  prdata = PdataW'(diam_q);
      default:      prdata = '0;
    endcase
  end

  // Effective dimension, saturated at the store depth
  logic [CmpW-1:0] dim_eff;
  assign dim_eff = (CmpW'(dim_q) > CmpW'(DimMax)) ? CmpW'(DimMax) : CmpW'(dim_q);

  // ---------------------------------------------------------------------------
  // Input word unpack
  // ---------------------------------------------------------------------------
  logic [FuncW-1:0]       in_func;
  logic [IdxW-1:0]        in_idx;
  logic signed [ValW-1:0] in_va;
  logic signed [ValW-1:0] in_vb;
  logic                   in_last;
  logic                   s_fire;

  assign in_func = s_axis_tuser_i;
  assign in_idx  = s_axis_tdata_i[IdxW-1:0];
  assign in_va   = s_axis_tdata_i[IdxW +: ValW];
  assign in_vb   = s_axis_tdata_i[IdxW+ValW +: ValW];
  assign in_last = s_axis_tlast_i;
  assign s_fire  = s_axis_tvalid_i && s_axis_tready_o;

  // ---------------------------------------------------------------------------
  // Focus store: both foci packed in one word per coordinate
  // ---------------------------------------------------------------------------
  logic            ram_we;
  logic [RamW-1:0] ram_rdata;

  assign ram_we = s_fire && (in_func == FuncLoad) && (CmpW'(in_idx) < CmpW'(DimMax));

  fse_ram #(
    .Width (RamW),
    .Depth (DimMax)
  ) u_focus_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (to_addr(in_idx)),
    .wdata_i ({in_vb, in_va}),
    .raddr_i (to_addr(in_idx)),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  fse_state_e state_q, state_d;
  logic       out_free;
  logic       out_load;
  logic       pt_last_q;
  fse_root_ctl_t root_one_ctl, root_two_ctl;

  assign out_free = !m_axis_tvalid_o || m_axis_tready_i;

  // tready is high in every branch that tests tvalid, so tvalid alone marks a take
  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    out_load        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i && (in_func == FuncPoint)) begin
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: begin
        s_axis_tready_o = !pt_last_q;
        if (pt_last_q) begin
          state_d = ST_ACC;
        end else if (s_axis_tvalid_i && (in_func == FuncPoint)) begin
          state_d = ST_MUL1;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ACC:   state_d = ST_START;
      ST_START: state_d = ST_ROOT;
      ST_ROOT: begin
        if (!root_one_ctl.busy && !root_two_ctl.busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Point capture and shared squaring multiplier
  // ---------------------------------------------------------------------------
  logic signed [ValW-1:0] pt_val_q;
  logic                   pt_use_q;
  logic                   acc2_pend_q;
  logic [MagW-1:0]        mag2_q;
  logic [ProdW-1:0]       prod_q;

  logic signed [ValW:0]   diff1, diff2;
  logic [ValW:0]          abs1, abs2;
  logic [MagW-1:0]        mul_a;

  assign diff1 = {pt_val_q[ValW-1], pt_val_q} - {ram_rdata[ValW-1], ram_rdata[ValW-1:0]};
  assign diff2 = {pt_val_q[ValW-1], pt_val_q} -
                 {ram_rdata[RamW-1], ram_rdata[RamW-1:ValW]};
  assign abs1  = diff1[ValW] ? (ValW+1)'(-diff1) : diff1;
  assign abs2  = diff2[ValW] ? (ValW+1)'(-diff2) : diff2;
  // MUL1 squares the distance to focus one, MUL2 the one kept for focus two
  assign mul_a = (state_q == ST_MUL1) ? abs1[MagW-1:0] : mag2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_use_q    <= 1'b0;
      pt_last_q   <= 1'b0;
      acc2_pend_q <= 1'b0;
    end else begin
      if (s_fire && (in_func == FuncPoint)) begin
        pt_use_q  <= CmpW'(in_idx) < dim_eff;
        pt_last_q <= in_last;
      end
      acc2_pend_q <= (state_q == ST_MUL2) && pt_use_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire && (in_func == FuncPoint)) begin
      pt_val_q <= in_va;
    end
    if (state_q == ST_MUL1) begin
      mag2_q <= abs2[MagW-1:0];
    end
    prod_q <= mul_a * mul_a;
  end

  // ---------------------------------------------------------------------------
  // Saturating square sums
  // ---------------------------------------------------------------------------
  logic [SumW-1:0] sum1_q, sum2_q;
  logic [SumW:0]   add1, add2;

  assign add1 = {1'b0, sum1_q} + (SumW+1)'(prod_q);
  assign add2 = {1'b0, sum2_q} + (SumW+1)'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum1_q <= '0;
      sum2_q <= '0;
    end else if (state_q == ST_START) begin
      // operands go into the root units at this edge
      sum1_q <= '0;
      sum2_q <= '0;
    end else begin
      if ((state_q == ST_MUL2) && pt_use_q) begin
        sum1_q <= add1[SumW] ? '1 : add1[SumW-1:0];
      end
      if (acc2_pend_q) begin
        sum2_q <= add2[SumW] ? '1 : add2[SumW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Square roots
  // ---------------------------------------------------------------------------
  logic [RootW-1:0] root1, root2;

  assign root_one_ctl.start = (state_q == ST_START);
  assign root_two_ctl.start = (state_q == ST_START);

  fse_isqrt u_root_one (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_one_ctl.start),
    .op_i    (sum1_q),
    .busy_o  (root_one_ctl.busy),
    .root_o  (root1)
  );

  fse_isqrt u_root_two (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_two_ctl.start),
    .op_i    (sum2_q),
    .busy_o  (root_two_ctl.busy),
    .root_o  (root2)
  );

  // Two 19-bit roots never exceed the 20-bit length, so no clamp is needed
  logic [LenW-1:0] len;
  logic            not_set;

  assign len     = LenW'(root1) + LenW'(root2);
  assign not_set = (diam_q == '0);

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic            out_valid_q;
  logic            out_inside_q;
  logic            out_surface_q;
  logic [LenW-1:0] out_len_q;
  logic            out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_inside_q  <= !not_set && (len < diam_q);
      out_surface_q <= !not_set && (len == diam_q);
      out_len_q     <= len;
      out_status_q  <= not_set ? StatusNotSet : StatusOk;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OutDataW-LenW-2)'(0), out_len_q, out_surface_q, out_inside_q};
  assign m_axis_tuser_o  = out_status_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_point_reads_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && (in_func == FuncPoint)) |=> (state_q == ST_MUL1))
    else $error("point word not followed by store read stage");

  a_sums_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_START) |=> (sum1_q == '0 && sum2_q == '0))
    else $error("square sums not cleared after root start");

  a_roots_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (!root_one_ctl.busy && !root_two_ctl.busy))
    else $error("result taken before both roots finished");

  a_no_pending_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_START) |-> !acc2_pend_q)
    else $error("second sum still pending at root start");

  a_not_set_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == StatusNotSet)) |->
      (!m_axis_tdata_o[0] && !m_axis_tdata_o[1]))
    else $error("compare flags raised with diameter unset");

endmodule
